[rtl/fir_filter_73_tap_fixed_point_macros.svh]
// Assertion macros for the 73-tap FIR filter.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef FIR_FILTER_73_TAP_FIXED_POINT_MACROS_SVH
`define FIR_FILTER_73_TAP_FIXED_POINT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FIR73_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir73: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FIR73_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir73: next-cycle check failed");

`endif

[rtl/fir73_pkg.sv]
// Shared types, constants and the coefficient ROM of the 73-tap FIR filter.
// No dependencies.
package fir73_pkg;

    localparam int TAPS     = 73;
    localparam int DEPTH    = TAPS - 1;
    localparam int TAP_W    = 7;
    localparam int ADDR_W   = 7;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 37;
    localparam int SHIFT    = 11;
    localparam int MID_TAP  = (TAPS - 1) / 2;

    typedef logic [TAP_W-1:0]           tap_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_FIN
    } seq_state_t;

    typedef struct packed {
        logic    vld;
        logic    first;
        logic    last;
        sample_t operand;
        coef_t   coef;
    } mac_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } mac_rsp_t;

    // Symmetric Q2.14 coefficients; taps past the center fold back.
    function automatic coef_t coef_rom(input tap_t tap);
        tap_t fold;
        coef_t c;
        fold = (tap > TAP_W'(MID_TAP)) ? TAP_W'(TAPS - 1) - tap : tap;
        unique case (fold)
            7'd0:    c = 16'sd423;
            7'd1:    c = 16'sd337;
            7'd2:    c = 16'sd465;
            7'd3:    c = 16'sd621;
            7'd4:    c = 16'sd808;
            7'd5:    c = 16'sd1027;
            7'd6:    c = 16'sd1281;
            7'd7:    c = 16'sd1572;
            7'd8:    c = 16'sd1902;
            7'd9:    c = 16'sd2272;
            7'd10:   c = 16'sd2682;
            7'd11:   c = 16'sd3133;
            7'd12:   c = 16'sd3624;
            7'd13:   c = 16'sd4154;
            7'd14:   c = 16'sd4721;
            7'd15:   c = 16'sd5323;
            7'd16:   c = 16'sd5956;
            7'd17:   c = 16'sd6617;
            7'd18:   c = 16'sd7300;
            7'd19:   c = 16'sd8002;
            7'd20:   c = 16'sd8715;
            7'd21:   c = 16'sd9435;
            7'd22:   c = 16'sd10154;
            7'd23:   c = 16'sd10866;
            7'd24:   c = 16'sd11563;
            7'd25:   c = 16'sd12238;
            7'd26:   c = 16'sd12884;
            7'd27:   c = 16'sd13493;
            7'd28:   c = 16'sd14060;
            7'd29:   c = 16'sd14577;
            7'd30:   c = 16'sd15039;
            7'd31:   c = 16'sd15445;
            7'd32:   c = 16'sd15774;
            7'd33:   c = 16'sd16038;
            7'd34:   c = 16'sd16230;
            7'd35:   c = 16'sd16345;
            7'd36:   c = 16'sd16384;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/fir73_in_if.sv]
// Input sample channel: valid/ready handshake with one Q6.10 sample.
// Depends on fir73_pkg.
interface fir73_in_if import fir73_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/fir73_out_if.sv]
// Result channel: valid/ready handshake with one Q3.13 filtered sample.
// Depends on fir73_pkg.
interface fir73_out_if import fir73_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/fir73_delay_mem.sv]
// Circular delay-line memory: one write and one registered read port.
// Depends on fir73_pkg.
module fir73_delay_mem import fir73_pkg::*;
(
    input  logic    clk,
    input  logic    we,
    input  addr_t   waddr,
    input  sample_t wdata,
    input  addr_t   raddr,
    output sample_t rdata
);

    sample_t mem [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fir73_mac.sv]
// Two-stage multiply-accumulate: registered product, then exact accumulate.
// Depends on fir73_pkg.
module fir73_mac import fir73_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_req_t req,
    output mac_rsp_t rsp
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_first_reg;
    logic                     prod_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg   <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_vld_reg   <= req.vld;
            prod_first_reg <= req.first;
            prod_last_reg  <= req.last;
            done_reg       <= prod_vld_reg && prod_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(req.operand) * $signed(req.coef);
        if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_next = prod_first_reg ? prod_ext : acc_reg + prod_ext;
    end

    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;

endmodule

[rtl/fir_filter_73_tap_fixed_point.sv]
// Top level of the 73-tap direct-form FIR filter: tap sequencer and output register.
// Depends on fir73_pkg, fir73_in_if, fir73_out_if, fir73_delay_mem, fir73_mac
// and the assertion macros header.
//
// Usage:
//   sample_chan carries one signed Q6.10 sample per transfer; result_chan returns
//   one signed Q3.13 sample per input, in order.
//   After a sample transfer the sequencer walks taps 0..72, one per cycle, through
//   a single multiplier and a 37-bit accumulator; the stored samples come from a
//   72-entry circular memory with one read port. The result becomes valid as the
//   sequencer returns to idle, and the next sample is taken in that same cycle,
//   so the block takes no new sample until the last one's result is registered.
//   ready on sample_chan is high only while no sample is in flight.
//   A result waits in the output register; if it is still untaken when the next
//   sum is done, that item holds until result_chan takes the old one.
//   Reset clears control state and the fill count; older samples not yet
//   received read as zero, so the memory needs no clearing pass.
//   The output wraps to 16 bits (bits 26..11 of the exact sum), no saturation.
`include "fir_filter_73_tap_fixed_point_macros.svh"

module fir_filter_73_tap_fixed_point import fir73_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    fir73_in_if.sink    sample_chan,
    fir73_out_if.source result_chan
);

    seq_state_t state_reg, state_next;
    tap_t       tap_reg, tap_next;
    addr_t      wp_reg, wp_next;
    tap_t       fill_reg, fill_next;
    sample_t    x_reg, x_next;
    logic       rd_vld_reg, rd_vld_next;
    tap_t       rd_tap_reg, rd_tap_next;
    logic       out_valid_reg, out_valid_next;
    sample_t    out_data_reg, out_data_next;

    logic       mem_we;
    addr_t      raddr;
    sample_t    rdata;
    logic [ADDR_W:0] wrap_sum;
    mac_req_t   mac_req;
    mac_rsp_t   mac_rsp;

    fir73_delay_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (x_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    fir73_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    // Sample n-k sits k entries behind the write pointer.
    always_comb
    begin
        if (wp_reg >= ADDR_W'(tap_reg))
        begin
            wrap_sum = {1'b0, wp_reg} - {1'b0, tap_reg};
        end
        else
        begin
            wrap_sum = {1'b0, wp_reg} + (ADDR_W + 1)'(DEPTH) - {1'b0, tap_reg};
        end
        raddr = wrap_sum[ADDR_W-1:0];
    end

    // Operand select: tap 0 is the new sample, unfilled history reads as zero.
    always_comb
    begin
        mac_req.vld   = rd_vld_reg;
        mac_req.first = (rd_tap_reg == '0);
        mac_req.last  = (rd_tap_reg == TAP_W'(TAPS - 1));
        mac_req.coef  = coef_rom(rd_tap_reg);
        if (rd_tap_reg == '0)
        begin
            mac_req.operand = x_reg;
        end
        else if (rd_tap_reg <= fill_reg)
        begin
            mac_req.operand = rdata;
        end
        else
        begin
            mac_req.operand = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rd_tap_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            rd_vld_reg    <= rd_vld_next;
            rd_tap_reg    <= rd_tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        x_next         = x_reg;
        rd_vld_next    = 1'b0;
        rd_tap_next    = tap_reg;
        out_valid_next = out_valid_reg && !result_chan.ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_chan.valid)
                begin
                    x_next     = sample_chan.sample_in;
                    tap_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rd_vld_next = 1'b1;
                tap_next    = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(TAPS - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mac_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Delay-line write comes after the last read of the oldest entry.
                if (!out_valid_reg || result_chan.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mac_rsp.acc[SHIFT+SAMPLE_W-1:SHIFT];
                    mem_we         = 1'b1;
                    wp_next        = (wp_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                    : wp_reg + ADDR_W'(1);
                    fill_next      = (fill_reg == TAP_W'(DEPTH)) ? fill_reg
                                                                 : fill_reg + TAP_W'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sample_chan.ready      = (state_reg == ST_IDLE);
    assign result_chan.valid      = out_valid_reg;
    assign result_chan.sample_out = out_data_reg;

    `FIR73_ASSERT_IMPL(a_tap_range, state_reg == ST_RUN, tap_reg <= TAP_W'(TAPS - 1))
    `FIR73_ASSERT_IMPL(a_fill_range, 1'b1, fill_reg <= TAP_W'(DEPTH))
    `FIR73_ASSERT_IMPL(a_done_in_wait, mac_rsp.done, state_reg == ST_WAIT)
    `FIR73_ASSERT_IMPL(a_idle_no_read, state_reg == ST_IDLE, !rd_vld_reg)
    `FIR73_ASSERT_NEXT(a_write_gives_result, mem_we, out_valid_reg)

endmodule
